// ===== sv/ppsr_pkg.sv =====
// Package: shared constants, command codes and types for the shape rasterizer.
`default_nettype none
package ppsr_pkg;
    localparam int PANEL_WIDTH_DEF  = 84;
    localparam int PANEL_HEIGHT_DEF = 48;
    localparam int BANK_HEIGHT      = 8;
    localparam int COORD_W          = 16;

    typedef enum logic [2:0] {
        CMD_PIXEL = 3'd0,
        CMD_LINE  = 3'd1,
        CMD_RECT  = 3'd2,
        CMD_FILL  = 3'd3,
        CMD_CIRC  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    // One decoded job handed from the front end to the drawing engine.
    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [7:0]         rect_width;
        logic [7:0]         rect_height;
        logic [7:0]         radius;
        logic               color;
        logic [2:0]         read_bank;
        logic [6:0]         read_column;
        logic               invalid;
    } job_t;
endpackage
`default_nettype wire

// ===== sv/ppsr_if.sv =====
// Interfaces: request and result channels of the shape rasterizer.
`default_nettype none
interface ppsr_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [7:0]         rect_width;
    logic [7:0]         rect_height;
    logic [7:0]         radius;
    logic               color;
    logic [2:0]         read_bank;
    logic [6:0]         read_column;
    modport source (output valid, command, start_x, start_y, end_x, end_y, rect_width,
                    rect_height, radius, color, read_bank, read_column, input ready);
    modport sink (input valid, command, start_x, start_y, end_x, end_y, rect_width,
                  rect_height, radius, color, read_bank, read_column, output ready);
endinterface

interface ppsr_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] read_data;
    modport source (output valid, status, read_data, input ready);
    modport sink (input valid, status, read_data, output ready);
endinterface
`default_nettype wire

// ===== sv/ppsr_front.sv =====
// Front end: accepts requests, checks parameters and queues decoded jobs.
`default_nettype none
module ppsr_front
    import ppsr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ppsr_req_if.sink  req,
    output job_t      job,
    output logic      job_valid,
    input  wire logic job_ready
);
    localparam int BANK_COUNT = (PANEL_HEIGHT + BANK_HEIGHT - 1) / BANK_HEIGHT;

    // Two-entry queue.
    job_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       dec;
    logic       push, pop;

    always_comb
    begin
        dec.command     = req.command;
        dec.start_x     = req.start_x;
        dec.start_y     = req.start_y;
        dec.end_x       = req.end_x;
        dec.end_y       = req.end_y;
        dec.rect_width  = req.rect_width;
        dec.rect_height = req.rect_height;
        dec.radius      = req.radius;
        dec.color       = req.color;
        dec.read_bank   = req.read_bank;
        dec.read_column = req.read_column;
        case (req.command)
            CMD_PIXEL: dec.invalid = req.start_x < 0 || req.start_y < 0
                       || 32'(req.start_x) >= PANEL_WIDTH
                       || 32'(req.start_y) >= PANEL_HEIGHT;
            CMD_LINE:  dec.invalid = 1'b0;
            CMD_RECT, CMD_FILL:
                       dec.invalid = req.rect_width == 8'd0 || req.rect_height == 8'd0;
            CMD_CIRC:  dec.invalid = 1'b0;
            CMD_READ:  dec.invalid = 32'(req.read_bank) >= BANK_COUNT
                       || 32'(req.read_column) >= PANEL_WIDTH;
            default:   dec.invalid = 1'b1;
        endcase
    end

    assign req.ready = cnt_reg != 2'd2;
    assign push      = req.valid && req.ready;
    assign job_valid = cnt_reg != 2'd0;
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rp_reg];
    assign wp_next   = wp_reg ^ push;
    assign rp_next   = rp_reg ^ pop;
    assign cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/ppsr_engine.sv =====
// Drawing engine: line and circle steppers with a frame store read-modify-write.
`default_nettype none
module ppsr_engine
    import ppsr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  job_t      job,
    input  wire logic job_valid,
    output logic      job_ready,
    ppsr_rsp_if.source rsp,
    output logic      busy
);
    localparam int BANK_COUNT = (PANEL_HEIGHT + BANK_HEIGHT - 1) / BANK_HEIGHT;
    localparam int DEPTH      = BANK_COUNT * PANEL_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int XW         = $clog2(PANEL_WIDTH);
    localparam int BW         = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SEG   = 9'b000000100,
        S_LINE  = 9'b000001000,
        S_CIRC  = 9'b000010000,
        S_CPT   = 9'b000100000,
        S_RD    = 9'b001000000,
        S_RD2   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    job_t   job_reg;

    // Line stepper.
    logic signed [17:0] lx_reg, ly_reg, lx1_reg, ly1_reg;
    logic signed [18:0] dx_reg, dy_reg, err_reg;
    logic signed [17:0] sgx_reg, sgy_reg;
    // Segment sequencer for rectangles.
    logic [7:0] seg_reg;
    // Circle stepper.
    logic signed [17:0] ox_reg, oy_reg;
    logic signed [19:0] cerr_reg;
    logic [2:0]         oct_reg;

    logic       status_reg;
    logic [7:0] data_reg;
    logic       out_valid_reg;

    // Frame store with a registered read, write via pipelined RMW.
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] clr_reg;
    // Pixel pipeline stage 1: address/mask.
    logic          p1_v_reg;
    logic [AW-1:0] p1_a_reg;
    logic [7:0]    p1_m_reg;
    logic          p1_c_reg;
    // Stage 2: write.
    logic          p2_v_reg;
    logic [AW-1:0] p2_a_reg;
    logic [7:0]    p2_d_reg;
    // The write that landed on the same edge as the stage 1 read.
    logic          p3_v_reg;
    logic [AW-1:0] p3_a_reg;
    logic [7:0]    p3_d_reg;

    // Current pixel request from stepper.
    logic               px_v;
    logic signed [15:0] px_x, px_y;
    logic               on_p;
    logic [AW-1:0]      px_a;
    logic [7:0]         px_m;

    always_comb
    begin
        on_p = px_x >= 0 && px_y >= 0 && 32'(px_x) < PANEL_WIDTH
               && 32'(px_y) < PANEL_HEIGHT;
        px_a = AW'((32'(px_y) >> 3) * PANEL_WIDTH + 32'(px_x));
        px_m = 8'(1) << px_y[2:0];
    end

    // Circle point selection.
    logic signed [15:0] cpx, cpy;
    always_comb
    begin
        case (oct_reg)
            3'd0:
            begin
                cpx = job_reg.start_x + ox_reg[15:0];
                cpy = job_reg.start_y + oy_reg[15:0];
            end
            3'd1:
            begin
                cpx = job_reg.start_x + oy_reg[15:0];
                cpy = job_reg.start_y + ox_reg[15:0];
            end
            3'd2:
            begin
                cpx = job_reg.start_x - oy_reg[15:0];
                cpy = job_reg.start_y + ox_reg[15:0];
            end
            3'd3:
            begin
                cpx = job_reg.start_x - ox_reg[15:0];
                cpy = job_reg.start_y + oy_reg[15:0];
            end
            3'd4:
            begin
                cpx = job_reg.start_x - ox_reg[15:0];
                cpy = job_reg.start_y - oy_reg[15:0];
            end
            3'd5:
            begin
                cpx = job_reg.start_x - oy_reg[15:0];
                cpy = job_reg.start_y - ox_reg[15:0];
            end
            3'd6:
            begin
                cpx = job_reg.start_x + oy_reg[15:0];
                cpy = job_reg.start_y - ox_reg[15:0];
            end
            default:
            begin
                cpx = job_reg.start_x + ox_reg[15:0];
                cpy = job_reg.start_y - oy_reg[15:0];
            end
        endcase
    end

    always_comb
    begin
        px_v = 1'b0;
        px_x = lx_reg[15:0];
        px_y = ly_reg[15:0];
        if (state_reg == S_LINE)
        begin
            px_v = 1'b1;
        end
        else if (state_reg == S_CPT)
        begin
            px_v = 1'b1;
            px_x = cpx;
            px_y = cpy;
        end
    end

    // Segment endpoints: rectangle edges and fill rows.
    logic signed [15:0] right, bottom, row;
    logic signed [15:0] sx0, sy0, sx1, sy1;
    logic [7:0]         seg_last;
    always_comb
    begin
        right  = job_reg.start_x + 16'(job_reg.rect_width) - 16'sd1;
        bottom = job_reg.start_y + 16'(job_reg.rect_height) - 16'sd1;
        row    = job_reg.start_y + 16'(seg_reg);
        sx0 = job_reg.start_x; sy0 = job_reg.start_y;
        sx1 = job_reg.end_x;   sy1 = job_reg.end_y;
        seg_last = 8'd0;
        if (job_reg.command == CMD_RECT)
        begin
            seg_last = 8'd3;
            case (seg_reg[1:0])
                2'd0: begin sx1 = right; sy1 = job_reg.start_y; end
                2'd1: begin sy0 = bottom; sx1 = right; sy1 = bottom; end
                2'd2: begin sx1 = job_reg.start_x; sy1 = bottom; end
                default: begin sx0 = right; sx1 = right; sy1 = bottom; end
            endcase
        end
        else if (job_reg.command == CMD_FILL)
        begin
            seg_last = job_reg.rect_height - 8'd1;
            sy0 = row; sx1 = right; sy1 = row;
        end
    end

    logic signed [19:0] e2;
    logic               lx_go, ly_go, ldone;
    always_comb
    begin
        e2    = {err_reg, 1'b0};
        lx_go = e2 > -20'(dy_reg);
        ly_go = e2 < 20'(dx_reg);
        ldone = lx_reg == lx1_reg && ly_reg == ly1_reg;
    end

    logic signed [17:0] oy_n;
    logic signed [19:0] cerr_a, ctest;
    always_comb
    begin
        oy_n   = oy_reg + 18'sd1;
        cerr_a = cerr_reg + 20'sd1 + 20'(oy_n <<< 1);
        ctest  = ((cerr_a - 20'(ox_reg)) <<< 1) + 20'sd1;
    end

    assign job_ready = state_reg == S_IDLE;
    assign busy      = state_reg != S_IDLE || p1_v_reg || p2_v_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.read_data = data_reg;

    // Bypass for read-after-write in the pixel pipeline. The newest write wins.
    logic [7:0] cur;
    always_comb
    begin
        cur = rdata_reg;
        if (p3_v_reg && p3_a_reg == p1_a_reg)
        begin
            cur = p3_d_reg;
        end
        if (p2_v_reg && p2_a_reg == p1_a_reg)
        begin
            cur = p2_d_reg;
        end
    end

    logic [AW-1:0] rd_a;
    assign rd_a = (state_reg == S_RD) ? AW'(32'(job_reg.read_bank[BW-1:0]) * PANEL_WIDTH
                                         + 32'(job_reg.read_column)) : px_a;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_a];
        if (state_reg == S_CLEAR)
        begin
            mem[clr_reg] <= 8'd0;
        end
        else if (p2_v_reg)
        begin
            mem[p2_a_reg] <= p2_d_reg;
        end
        p1_a_reg <= px_a;
        p1_m_reg <= px_m;
        p1_c_reg <= job_reg.color;
        p2_a_reg <= p1_a_reg;
        p2_d_reg <= p1_c_reg ? (cur | p1_m_reg) : (cur & ~p1_m_reg);
        p3_a_reg <= p2_a_reg;
        p3_d_reg <= p2_d_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:
                if (job_valid)
                begin
                    if (job.invalid) state_next = S_OUT;
                    else
                    begin
                        case (job.command)
                            CMD_CIRC: state_next = S_CPT;
                            CMD_READ: state_next = S_RD;
                            CMD_PIXEL: state_next = S_LINE;
                            default:  state_next = S_SEG;
                        endcase
                    end
                end
            S_SEG:  state_next = S_LINE;
            S_LINE:
                if (ldone)
                begin
                    if (job_reg.command != CMD_PIXEL && job_reg.command != CMD_LINE
                        && seg_reg != seg_last)
                        state_next = S_SEG;
                    else
                        state_next = S_RD;
                end
            S_CPT:  if (oct_reg == 3'd7) state_next = S_CIRC;
            // Continue while the updated x offset still reaches the updated y offset.
            S_CIRC: state_next = (oy_n <= ox_reg - ((ctest > 0) ? 18'sd1 : 18'sd0))
                                 ? S_CPT : S_RD;
            S_RD:   state_next = S_RD2;
            S_RD2:  state_next = S_OUT;
            S_OUT:  if (rsp.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                job_reg  <= job;
                seg_reg  <= 8'd0;
                oct_reg  <= 3'd0;
                ox_reg   <= 18'(job.radius);
                oy_reg   <= 18'sd0;
                cerr_reg <= 20'sd0;
                lx_reg   <= 18'(job.start_x);
                ly_reg   <= 18'(job.start_y);
                lx1_reg  <= 18'(job.start_x);
                ly1_reg  <= 18'(job.start_y);
            end
            S_SEG:
            begin
                lx_reg  <= 18'(sx0);
                ly_reg  <= 18'(sy0);
                lx1_reg <= 18'(sx1);
                ly1_reg <= 18'(sy1);
                sgx_reg <= (sx0 < sx1) ? 18'sd1 : -18'sd1;
                sgy_reg <= (sy0 < sy1) ? 18'sd1 : -18'sd1;
                dx_reg  <= (sx1 > sx0) ? 19'(sx1) - 19'(sx0) : 19'(sx0) - 19'(sx1);
                dy_reg  <= (sy1 > sy0) ? 19'(sy1) - 19'(sy0) : 19'(sy0) - 19'(sy1);
                err_reg <= ((sx1 > sx0) ? 19'(sx1) - 19'(sx0) : 19'(sx0) - 19'(sx1))
                         - ((sy1 > sy0) ? 19'(sy1) - 19'(sy0) : 19'(sy0) - 19'(sy1));
            end
            S_LINE:
            begin
                if (ldone) seg_reg <= seg_reg + 8'd1;
                else
                begin
                    err_reg <= err_reg - (lx_go ? dy_reg : 19'sd0)
                             + (ly_go ? dx_reg : 19'sd0);
                    if (lx_go) lx_reg <= lx_reg + sgx_reg;
                    if (ly_go) ly_reg <= ly_reg + sgy_reg;
                end
            end
            S_CPT: oct_reg <= oct_reg + 3'd1;
            S_CIRC:
            begin
                oy_reg <= oy_n;
                if (ctest > 0)
                begin
                    ox_reg   <= ox_reg - 18'sd1;
                    cerr_reg <= cerr_a + 20'sd1 - 20'((ox_reg - 18'sd1) <<< 1);
                end
                else cerr_reg <= cerr_a;
            end
            S_RD2:
            begin
                status_reg <= 1'b0;
                data_reg   <= (job_reg.command == CMD_READ) ? rdata_reg : 8'd0;
            end
            default:
            begin
                if (state_reg == S_IDLE || state_next != S_OUT || state_reg == S_OUT)
                begin
                    status_reg <= status_reg;
                end
            end
        endcase
        if (state_reg == S_IDLE && job_valid && job.invalid)
        begin
            status_reg <= 1'b1;
            data_reg   <= 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + AW'(1);
            p1_v_reg <= px_v && on_p;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            if (state_next == S_OUT && state_reg != S_OUT) out_valid_reg <= 1'b1;
            else if (rsp.ready) out_valid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== sv/page_packed_shape_rasterizer_core.sv =====
// Top level of the page-packed shape rasterizer: front end, job queue and drawing engine.
//
// Requests arrive on the req channel (valid/ready), one drawing or read command per
// request. The front end checks parameters and places the job in a two-entry queue,
// so new requests are accepted while the engine draws. The engine steps a Bresenham
// line or a midpoint circle one pixel per cycle; each pixel is a read-modify-write of
// the frame store through a two-stage pipeline with forwarding paths.
// Each request yields exactly one result on the rsp channel carrying status and,
// for a read command, the stored byte.
// Each drawn pixel is one engine step; a circle step draws its eight points and then
// makes one update, and each rectangle edge or fill row begins with a setup step.
// The engine takes a new job only once the previous result has been accepted, and
// the store has a single write port.
// After reset the store is cleared, one byte per cycle, over all BANK_COUNT*PANEL_WIDTH
// bytes (504 by default); requests are queued but not executed meanwhile.
// When the receiver holds ready low the result is held and the engine waits;
// the queue fills and then req.ready drops.
`default_nettype none
module page_packed_shape_rasterizer_core
    import ppsr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ppsr_req_if.sink   req,
    ppsr_rsp_if.source rsp
);
    job_t job;
    logic job_valid, job_ready, busy;

    ppsr_front #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .job(job), .job_valid(job_valid), .job_ready(job_ready)
    );

    ppsr_engine #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_engine (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid),
        .job_ready(job_ready), .rsp(rsp), .busy(busy)
    );

`ifndef ASSERT_OFF
    // A result is never shown while the engine reports itself idle.
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> busy) else $error("result without active job");
    // A job is only taken while no result is pending.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |-> !rsp.valid) else $error("job taken over result");
`endif
endmodule
`default_nettype wire

// ===== test/ppsr_scoreboard.sv =====
// Checker: watches both channels, predicts each result and compares it with the block.
`default_nettype none
module ppsr_scoreboard
    import ppsr_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ppsr_req_if       req,
    ppsr_rsp_if       rsp,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANKS      = (PANEL_HEIGHT + BANK_HEIGHT - 1) / BANK_HEIGHT;
    localparam int STORE_SIZE = BANKS * PANEL_WIDTH;

    typedef struct {
        logic       status;
        logic [7:0] read_data;
    } result_t;

    logic [7:0] shadow_store [STORE_SIZE];
    result_t    expected_results [$];

    function automatic int wrap16(int v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    function automatic bit on_panel(int x, int y);
        return x >= 0 && x < PANEL_WIDTH && y >= 0 && y < PANEL_HEIGHT;
    endfunction

    function automatic void plot(int x, int y, logic color);
        int idx;
        if (!on_panel(x, y))
            return;
        idx = (y / BANK_HEIGHT) * PANEL_WIDTH + x;
        shadow_store[idx][y % BANK_HEIGHT] = color;
    endfunction

    function automatic void trace_line(int x, int y, int x1, int y1, logic color);
        int dx, dy, sx, sy, err, e2;
        dx = (x1 > x) ? x1 - x : x - x1;
        dy = (y1 > y) ? y1 - y : y - y1;
        sx = (x < x1) ? 1 : -1;
        sy = (y < y1) ? 1 : -1;
        err = dx - dy;
        forever
        begin
            plot(x, y, color);
            if (x == x1 && y == y1)
                break;
            e2 = 2 * err;
            if (e2 > -dy)
            begin
                err -= dy;
                x += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y += sy;
            end
        end
    endfunction

    function automatic void trace_circle(int cx, int cy, int r, logic color);
        int ox, oy, err;
        ox = r;
        oy = 0;
        err = 0;
        while (ox >= oy)
        begin
            plot(wrap16(cx + ox), wrap16(cy + oy), color);
            plot(wrap16(cx + oy), wrap16(cy + ox), color);
            plot(wrap16(cx - oy), wrap16(cy + ox), color);
            plot(wrap16(cx - ox), wrap16(cy + oy), color);
            plot(wrap16(cx - ox), wrap16(cy - oy), color);
            plot(wrap16(cx - oy), wrap16(cy - ox), color);
            plot(wrap16(cx + oy), wrap16(cy - ox), color);
            plot(wrap16(cx + ox), wrap16(cy - oy), color);
            oy += 1;
            err += 1 + 2 * oy;
            if (2 * (err - ox) + 1 > 0)
            begin
                ox -= 1;
                err += 1 - 2 * ox;
            end
        end
    endfunction

    // Applies one accepted request to the shadow store and returns its result.
    function automatic result_t rasterize(logic [2:0] command, int sx, int sy, int ex,
                                          int ey, int w, int h, int rad, logic color,
                                          int bank, int col);
        result_t res;
        int right, bottom;
        res.status = 1'b0;
        res.read_data = '0;
        case (command)
            CMD_PIXEL:
                if (on_panel(sx, sy))
                    plot(sx, sy, color);
                else
                    res.status = 1'b1;
            CMD_LINE:
                trace_line(sx, sy, ex, ey, color);
            CMD_RECT:
                if (w == 0 || h == 0)
                    res.status = 1'b1;
                else
                begin
                    right = wrap16(sx + w - 1);
                    bottom = wrap16(sy + h - 1);
                    trace_line(sx, sy, right, sy, color);
                    trace_line(sx, bottom, right, bottom, color);
                    trace_line(sx, sy, sx, bottom, color);
                    trace_line(right, sy, right, bottom, color);
                end
            CMD_FILL:
                if (w == 0 || h == 0)
                    res.status = 1'b1;
                else
                begin
                    right = wrap16(sx + w - 1);
                    for (int i = 0; i < h; i++)
                        trace_line(sx, wrap16(sy + i), right, wrap16(sy + i), color);
                end
            CMD_CIRC:
                trace_circle(sx, sy, rad, color);
            CMD_READ:
                if (bank < BANKS && col < PANEL_WIDTH)
                    res.read_data = shadow_store[bank * PANEL_WIDTH + col];
                else
                    res.status = 1'b1;
            default:
                res.status = 1'b1;
        endcase
        return res;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            expected_results.delete();
            fail_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result status=%0d data=%02h",
                                 rsp.status, rsp.read_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status || rsp.read_data !== want.read_data)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: result mismatch: want status=%0d data=%02h, got status=%0d data=%02h",
                                     want.status, want.read_data, rsp.status, rsp.read_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_results.push_back(rasterize(req.command, int'(req.start_x),
                    int'(req.start_y), int'(req.end_x), int'(req.end_y),
                    int'(req.rect_width), int'(req.rect_height), int'(req.radius),
                    req.color, int'(req.read_bank), int'(req.read_column)));
        end
    end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench top: clock, reset, request stimulus, result back-pressure and the verdict.
`default_nettype none
module tb_top;
    import ppsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;

    // Idle percentages for the sender and stall percentages for the receiver.
    int   send_idle_pct;
    int   recv_stall_pct;

    ppsr_req_if req ();
    ppsr_rsp_if rsp ();

    page_packed_shape_rasterizer_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ppsr_scoreboard checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    typedef struct {
        logic [2:0]         command;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [7:0]         rect_width;
        logic [7:0]         rect_height;
        logic [7:0]         radius;
        logic               color;
        logic [2:0]         read_bank;
        logic [6:0]         read_column;
    } request_t;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The run is bounded well above the slowest legal run: the reset clear pass, one
    // full-range line and one maximal fill, and several hundred small shapes.
    initial
    begin
        #80_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // The receiver decides at each falling edge whether to accept a result.
    always @(negedge clk)
    begin
        rsp.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Builds a request with every field at a known value.
    function automatic request_t make_request(logic [2:0] command, int sx, int sy, int ex,
                                              int ey, int w, int h, int rad, logic color,
                                              int bank, int col);
        request_t r;
        r.command = command;
        r.start_x = sx[15:0];
        r.start_y = sy[15:0];
        r.end_x = ex[15:0];
        r.end_y = ey[15:0];
        r.rect_width = w[7:0];
        r.rect_height = h[7:0];
        r.radius = rad[7:0];
        r.color = color;
        r.read_bank = bank[2:0];
        r.read_column = col[6:0];
        return r;
    endfunction

    // Presents one request at a falling edge, after optional idle cycles, and returns
    // once it has been accepted. Valid stays high so back-to-back requests need no
    // second assignment in one time step.
    task automatic send_request(request_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.command = r.command;
        req.start_x = r.start_x;
        req.start_y = r.start_y;
        req.end_x = r.end_x;
        req.end_y = r.end_y;
        req.rect_width = r.rect_width;
        req.rect_height = r.rect_height;
        req.radius = r.radius;
        req.color = r.color;
        req.read_bank = r.read_bank;
        req.read_column = r.read_column;
        req.valid = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        @(negedge clk);
        req.valid = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Coordinates mostly land around the panel so shapes stay short and visible;
    // an occasional full-range value exercises the upper bits.
    function automatic int near_coord();
        return $urandom_range(0, 115) - 16;
    endfunction

    function automatic int any_coord();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(0, 65535));
        return near_coord();
    endfunction

    function automatic request_t random_request();
        int pick;
        int w, h;
        logic [2:0] command;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            command = CMD_PIXEL;
        else if (pick < 35)
            command = CMD_LINE;
        else if (pick < 47)
            command = CMD_RECT;
        else if (pick < 57)
            command = CMD_FILL;
        else if (pick < 67)
            command = CMD_CIRC;
        else if (pick < 96)
            command = CMD_READ;
        else
            command = 3'(6 + $urandom_range(0, 1));
        // Sizes are mostly small; zero shows up now and then as an invalid extent.
        w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 48);
        h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
        if (command == CMD_RECT && $urandom_range(0, 7) == 0)
        begin
            w = $urandom_range(0, 255);
            h = $urandom_range(0, 255);
        end
        // Lines keep both ends near the panel since the engine walks every step.
        if (command == CMD_LINE)
            return make_request(command, near_coord(), near_coord(), near_coord(),
                near_coord(), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 7),
                $urandom_range(0, 127));
        if (command == CMD_READ)
            return make_request(command, any_coord(), any_coord(), any_coord(), any_coord(),
                w, h, $urandom_range(0, 255), $urandom_range(0, 1),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 5),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 83));
        if (command == CMD_RECT || command == CMD_FILL)
            return make_request(command, near_coord(), near_coord(), any_coord(), any_coord(),
                w, h, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 7),
                $urandom_range(0, 127));
        return make_request(command, any_coord(), any_coord(), any_coord(), any_coord(),
            w, h, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 7),
            $urandom_range(0, 127));
    endfunction

    initial
    begin
        request_t directed [$];
        int phase_idle [4];
        int phase_stall [4];

        req.valid = 1'b0;
        req.command = CMD_PIXEL;
        req.start_x = '0;
        req.start_y = '0;
        req.end_x = '0;
        req.end_y = '0;
        req.rect_width = '0;
        req.rect_height = '0;
        req.radius = '0;
        req.color = 1'b0;
        req.read_bank = '0;
        req.read_column = '0;
        rsp.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: panel corners, off-panel pixels, read bounds, every shape,
        // invalid extents, 16-bit corner and circle wrap, unused command codes.
        directed.push_back(make_request(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_PIXEL, 83, 47, 0, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_PIXEL, -1, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_PIXEL, 84, 48, 0, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_PIXEL, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 5, 83));
        directed.push_back(make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6, 0));
        directed.push_back(make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 7, 127));
        directed.push_back(make_request(CMD_LINE, 0, 10, 83, 10, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_LINE, 20, 47, 20, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_LINE, 70, 40, 5, 3, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_request(CMD_LINE, 9, 9, 9, 9, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_LINE, -32768, -32768, 32767, 32767,
                                        0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_RECT, 5, 5, 0, 0, 0, 10, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_FILL, 5, 5, 0, 0, 10, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_RECT, -100, -100, 0, 0, 255, 255, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_FILL, 30, 20, 0, 0, 20, 10, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_FILL, -100, -100, 0, 0, 255, 255, 0, 0, 0, 0));
        directed.push_back(make_request(CMD_FILL, 32760, 4, 0, 0, 20, 1, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_CIRC, 40, 20, 0, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_request(CMD_CIRC, 40, 20, 0, 0, 0, 0, 255, 1, 0, 0));
        directed.push_back(make_request(CMD_CIRC, 32767, -32768, 0, 0, 0, 0, 10, 1, 0, 0));
        directed.push_back(make_request(3'd6, 1, 1, 0, 0, 1, 1, 1, 1, 0, 0));
        directed.push_back(make_request(3'd7, 1, 1, 0, 0, 1, 1, 1, 1, 1, 1));
        foreach (directed[i])
            send_request(directed[i]);
        drain_results();

        // Random part in four back-pressure phases: none, sender idle, receiver
        // stalling, and both. Each phase ends with the sender waiting for all results.
        phase_idle = '{0, 80, 0, 27};
        phase_stall = '{0, 0, 80, 27};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int n = 0; n < 138; n++)
                send_request(random_request());
            drain_results();
        end

        // Let the block settle and catch any stray result after the last one due.
        recv_stall_pct = 0;
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
